@@ rtl/lrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrs_pkg: link reconnect supervisor shared definitions
// Types, register indexes, phase codes and reset values used across the block.
// ----------------------------------------------------------------------------
package lrs_pkg;

  localparam int unsigned CFG_REGS  = 5;
  localparam int unsigned CFG_AW    = $clog2(CFG_REGS);
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned IN_DW     = 48;
  localparam int unsigned IN_UW     = 1;
  localparam int unsigned OUT_DW    = 184;
  localparam int unsigned CNT_NUM   = 5;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_CONFIG_VALID    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CONNECT_TIMEOUT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REFRESH_IVL     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BACKOFF_MIN     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BACKOFF_MAX     = 3'd4;

  // configuration reset values
  localparam logic [31:0] RST_CONNECT_TIMEOUT = 32'd15000;
  localparam logic [31:0] RST_REFRESH_IVL     = 32'd5000;
  localparam logic [31:0] RST_BACKOFF_MIN     = 32'd1000;
  localparam logic [31:0] RST_BACKOFF_MAX     = 32'd60000;

  // phase codes as seen on the result beat
  localparam logic [1:0] PHASE_IDLE       = 2'd0;
  localparam logic [1:0] PHASE_CONNECTING = 2'd1;
  localparam logic [1:0] PHASE_CONNECTED  = 2'd2;
  localparam logic [1:0] PHASE_WAIT       = 2'd3;

  // input kind
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // event counter slots
  localparam int unsigned CNT_ATTEMPT    = 0;
  localparam int unsigned CNT_SUCCESS    = 1;
  localparam int unsigned CNT_RECONNECT  = 2;
  localparam int unsigned CNT_DISCONNECT = 3;
  localparam int unsigned CNT_TIMEOUT    = 4;

  typedef struct packed {
    logic        config_valid;
    logic [31:0] conn_limit_ms;
    logic [31:0] refresh_interval_ms;
    logic [31:0] backoff_min_ms;
    logic [31:0] backoff_max_ms;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [31:0]        now_ms;
    logic               link_up;
    logic signed [7:0]  rssi_sample;
  } item_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               start_connect;
    logic               drop_link;
    logic signed [7:0]  rssi_now;
    logic signed [7:0]  rssi_floor;
    logic               rssi_floor_valid;
    logic [31:0]        attempt_count;
    logic [31:0]        success_count;
    logic [31:0]        reconnect_count;
    logic [31:0]        disconnect_count;
    logic [31:0]        timeout_count;
  } result_t;

endpackage

@@ rtl/lrs_cfg.sv @@
// ----------------------------------------------------------------------------
// lrs_cfg: configuration register file
// Holds the five supervisor settings, written through a plain write port.
// ----------------------------------------------------------------------------
module lrs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lrs_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [lrs_pkg::CFG_DW-1:0]  cfg_wdata,
  output lrs_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.config_valid        <= 1'b1;
      cfg.conn_limit_ms       <= lrs_pkg::RST_CONNECT_TIMEOUT;
      cfg.refresh_interval_ms <= lrs_pkg::RST_REFRESH_IVL;
      cfg.backoff_min_ms      <= lrs_pkg::RST_BACKOFF_MIN;
      cfg.backoff_max_ms      <= lrs_pkg::RST_BACKOFF_MAX;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lrs_pkg::REG_CONFIG_VALID:    cfg.config_valid        <= cfg_wdata[0];
        lrs_pkg::REG_CONNECT_TIMEOUT: cfg.conn_limit_ms       <= cfg_wdata;
        lrs_pkg::REG_REFRESH_IVL:     cfg.refresh_interval_ms <= cfg_wdata;
        lrs_pkg::REG_BACKOFF_MIN:     cfg.backoff_min_ms      <= cfg_wdata;
        lrs_pkg::REG_BACKOFF_MAX:     cfg.backoff_max_ms      <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/lrs_core.sv @@
// ----------------------------------------------------------------------------
// lrs_core: supervisor state and single-pass update
// Holds phase, timers, backoff, RSSI and counters; updates them per beat.
// ----------------------------------------------------------------------------
module lrs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  lrs_pkg::cfg_t     cfg,
  input  lrs_pkg::item_t    item,
  output lrs_pkg::result_t  res
);

  typedef enum logic [1:0] {
    ST_IDLE       = lrs_pkg::PHASE_IDLE,
    ST_CONNECTING = lrs_pkg::PHASE_CONNECTING,
    ST_CONNECTED  = lrs_pkg::PHASE_CONNECTED,
    ST_WAIT       = lrs_pkg::PHASE_WAIT
  } phase_t;

  phase_t             phase, phase_next;
  logic               armed, armed_next;
  logic [31:0]        attempt_start, attempt_start_next;
  logic [31:0]        refresh_start, refresh_start_next;
  logic [31:0]        retry_start, retry_start_next;
  logic [31:0]        retry_delay, retry_delay_next;
  logic [31:0]        backoff, backoff_next;
  logic signed [7:0]  rssi_hold, rssi_hold_next;
  logic signed [7:0]  rssi_low, rssi_low_next;
  logic               rssi_low_valid, rssi_low_valid_next;
  logic [31:0]        cnt [lrs_pkg::CNT_NUM];
  logic [31:0]        cnt_next [lrs_pkg::CNT_NUM];

  logic               start_pulse, drop_pulse;
  logic [31:0]        ref_start, ref_limit, elapsed;
  logic               expired;

  // Double the retry delay, saturating at the ceiling.
  function automatic logic [31:0] grow(input logic [31:0] cur, input logic [31:0] ceil);
    logic [31:0] dbl;
    dbl = {cur[30:0], 1'b0};
    if (cur >= (ceil >> 1)) begin
      return ceil;
    end else if (dbl > ceil) begin
      return ceil;
    end else begin
      return dbl;
    end
  endfunction

  // One elapsed-time compare, its operands picked by phase.
  always_comb begin
    case (phase)
      ST_CONNECTING: begin
        ref_start = attempt_start;
        ref_limit = cfg.conn_limit_ms;
      end
      ST_CONNECTED: begin
        ref_start = refresh_start;
        ref_limit = cfg.refresh_interval_ms;
      end
      default: begin
        ref_start = retry_start;
        ref_limit = retry_delay;
      end
    endcase
    elapsed = item.now_ms - ref_start;
    expired = elapsed >= ref_limit;
  end

  always_comb begin
    phase_next          = phase;
    armed_next          = armed;
    attempt_start_next  = attempt_start;
    refresh_start_next  = refresh_start;
    retry_start_next    = retry_start;
    retry_delay_next    = retry_delay;
    backoff_next        = backoff;
    rssi_hold_next      = rssi_hold;
    rssi_low_next       = rssi_low;
    rssi_low_valid_next = rssi_low_valid;
    cnt_next            = cnt;
    start_pulse         = 1'b0;
    drop_pulse          = 1'b0;

    if (item.op == lrs_pkg::OP_START) begin
      rssi_hold_next = '0;
      backoff_next   = cfg.backoff_min_ms;
      if (!cfg.config_valid) begin
        armed_next = 1'b0;
        phase_next = ST_IDLE;
      end else begin
        armed_next = 1'b1;
        cnt_next[lrs_pkg::CNT_ATTEMPT] = cnt[lrs_pkg::CNT_ATTEMPT] + 32'd1;
        phase_next         = ST_CONNECTING;
        attempt_start_next = item.now_ms;
        start_pulse        = 1'b1;
      end
    end else if (armed) begin
      if (item.link_up && phase != ST_CONNECTED) begin
        phase_next = ST_CONNECTED;
        cnt_next[lrs_pkg::CNT_SUCCESS] = cnt[lrs_pkg::CNT_SUCCESS] + 32'd1;
        if (cnt[lrs_pkg::CNT_SUCCESS] != '0) begin
          cnt_next[lrs_pkg::CNT_RECONNECT] = cnt[lrs_pkg::CNT_RECONNECT] + 32'd1;
        end
        backoff_next = cfg.backoff_min_ms;
        rssi_hold_next = item.rssi_sample;
        if (!rssi_low_valid || item.rssi_sample < rssi_low) begin
          rssi_low_next       = item.rssi_sample;
          rssi_low_valid_next = 1'b1;
        end
        refresh_start_next = item.now_ms;
      end else begin
        unique case (phase) inside
          ST_CONNECTING, ST_CONNECTED: begin
            if ((phase == ST_CONNECTING && expired) ||
                (phase == ST_CONNECTED && !item.link_up)) begin
              // drop: a timeout while connecting, a disconnect once up
              if (phase == ST_CONNECTED) begin
                cnt_next[lrs_pkg::CNT_DISCONNECT] = cnt[lrs_pkg::CNT_DISCONNECT] + 32'd1;
              end else begin
                cnt_next[lrs_pkg::CNT_TIMEOUT] = cnt[lrs_pkg::CNT_TIMEOUT] + 32'd1;
              end
              rssi_hold_next   = '0;
              drop_pulse       = 1'b1;
              phase_next       = ST_WAIT;
              retry_start_next = item.now_ms;
              retry_delay_next = backoff;
              backoff_next     = grow(backoff, cfg.backoff_max_ms);
            end else if (phase == ST_CONNECTED && expired) begin
              rssi_hold_next = item.rssi_sample;
              if (!rssi_low_valid || item.rssi_sample < rssi_low) begin
                rssi_low_next       = item.rssi_sample;
                rssi_low_valid_next = 1'b1;
              end
              refresh_start_next = item.now_ms;
            end
          end
          ST_WAIT: begin
            if (expired) begin
              cnt_next[lrs_pkg::CNT_ATTEMPT] = cnt[lrs_pkg::CNT_ATTEMPT] + 32'd1;
              phase_next         = ST_CONNECTING;
              attempt_start_next = item.now_ms;
              start_pulse        = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ST_IDLE;
      armed          <= 1'b0;
      attempt_start  <= '0;
      refresh_start  <= '0;
      retry_start    <= '0;
      retry_delay    <= '0;
      backoff        <= lrs_pkg::RST_BACKOFF_MIN;
      rssi_hold      <= '0;
      rssi_low       <= '0;
      rssi_low_valid <= 1'b0;
      for (int i = 0; i < lrs_pkg::CNT_NUM; i++) begin
        cnt[i] <= '0;
      end
    end else if (advance) begin
      phase          <= phase_next;
      armed          <= armed_next;
      attempt_start  <= attempt_start_next;
      refresh_start  <= refresh_start_next;
      retry_start    <= retry_start_next;
      retry_delay    <= retry_delay_next;
      backoff        <= backoff_next;
      rssi_hold      <= rssi_hold_next;
      rssi_low       <= rssi_low_next;
      rssi_low_valid <= rssi_low_valid_next;
      cnt            <= cnt_next;
    end
  end

  assign res.phase            = phase_next;
  assign res.start_connect    = start_pulse;
  assign res.drop_link        = drop_pulse;
  assign res.rssi_now         = rssi_hold_next;
  assign res.rssi_floor       = rssi_low_valid_next ? rssi_low_next : 8'sd0;
  assign res.rssi_floor_valid = rssi_low_valid_next;
  assign res.attempt_count    = cnt_next[lrs_pkg::CNT_ATTEMPT];
  assign res.success_count    = cnt_next[lrs_pkg::CNT_SUCCESS];
  assign res.reconnect_count  = cnt_next[lrs_pkg::CNT_RECONNECT];
  assign res.disconnect_count = cnt_next[lrs_pkg::CNT_DISCONNECT];
  assign res.timeout_count    = cnt_next[lrs_pkg::CNT_TIMEOUT];

endmodule

@@ rtl/link_reconnect_supervisor.sv @@
// ----------------------------------------------------------------------------
// link_reconnect_supervisor: radio link connect/retry supervisor
// Stream-in commands and ticks, stream-out phase, pulses, RSSI and counters.
// ----------------------------------------------------------------------------
// Every input beat (a start command or a timestamped tick) yields exactly one
// result beat. The block takes one beat per clock while the result side does
// not stall. Each beat is held in the input register, then takes a single
// combinational pass (one elapsed-time subtract and compare, the phase update,
// one increment per counter) into the result register. The state update in
// lrs_core is that one pass, so back-to-back beats run at full rate. Backpressure
// on the result side stalls the chain; the input register still takes one more
// beat while a finished result waits. Configuration is written through the
// cfg_we/cfg_addr/cfg_wdata port and must only change while no beat is in
// flight.
module link_reconnect_supervisor (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [lrs_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [lrs_pkg::CFG_DW-1:0]   cfg_wdata,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [31:0] now_ms, [32] link_up, [40:33] rssi_sample, [47:41] zero
  input  logic [lrs_pkg::IN_DW-1:0]    s_tdata,
  // [0] op
  input  logic [lrs_pkg::IN_UW-1:0]    s_tuser,
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [1:0] phase, [2] start_connect, [3] drop_link, [11:4] rssi_now,
  // [19:12] rssi_floor, [20] rssi_floor_valid, [52:21] attempt_count,
  // [84:53] success_count, [116:85] reconnect_count,
  // [148:117] disconnect_count, [180:149] timeout_count, [183:181] zero
  output logic [lrs_pkg::OUT_DW-1:0]   m_tdata
);

  lrs_pkg::cfg_t     cfg;
  lrs_pkg::item_t    in_item;
  lrs_pkg::result_t  res, out_res;
  logic              in_valid;
  logic              out_valid;
  logic              advance;

  lrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // move the held beat into the result register when that slot frees up;
  // hold tready low through reset so no beat is taken and then dropped
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !rst && (!in_valid || advance);

  // input register: hold one beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op          <= s_tuser[0];
      in_item.now_ms      <= s_tdata[31:0];
      in_item.link_up     <= s_tdata[32];
      in_item.rssi_sample <= s_tdata[40:33];
    end
  end

  lrs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .item    (in_item),
    .res     (res)
  );

  // result register: drop the valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000,
                     out_res.timeout_count,
                     out_res.disconnect_count,
                     out_res.reconnect_count,
                     out_res.success_count,
                     out_res.attempt_count,
                     out_res.rssi_floor_valid,
                     out_res.rssi_floor,
                     out_res.rssi_now,
                     out_res.drop_link,
                     out_res.start_connect,
                     out_res.phase};

  // a beat never both starts and drops the link
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_res.start_connect && out_res.drop_link))
    else $error("start and drop pulses on the same beat");

  // a drop always leaves the block waiting to retry
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.drop_link) |-> (out_res.phase == lrs_pkg::PHASE_WAIT))
    else $error("drop pulse without wait phase");

  // a start pulse always leaves the block connecting
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.start_connect) |-> (out_res.phase == lrs_pkg::PHASE_CONNECTING))
    else $error("start pulse without connecting phase");

  // idle carries no RSSI and no pulses
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.phase == lrs_pkg::PHASE_IDLE) |->
      (out_res.rssi_now == 8'sd0 && !out_res.start_connect && !out_res.drop_link))
    else $error("idle beat with RSSI or pulse");

endmodule

@@ verif/link_reconnect_supervisor_test.sv @@
// ----------------------------------------------------------------------------
// link_reconnect_supervisor_test: self-checking bench for the link supervisor
// Drives start and tick beats with random gaps and result stalls. Every result
// beat is compared field by field against a behavioral model of the
// connect/retry state machine. A short scripted sequence comes first, then
// randomized register settings and beat streams.
// ----------------------------------------------------------------------------
module link_reconnect_supervisor_test;

  // one row of the scripted opening: a register write or an input beat
  typedef struct packed {
    logic                       wr;
    logic [lrs_pkg::CFG_AW-1:0] idx;
    logic [31:0]                val;
    lrs_pkg::item_t             beat;
    logic                       typed;   // phase/pulses below override the model
    logic [1:0]                 phase;
    logic                       start;
    logic                       drop;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [lrs_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [lrs_pkg::CFG_DW-1:0]   cfg_wdata = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [lrs_pkg::IN_DW-1:0]    s_tdata = '0;
  logic [lrs_pkg::IN_UW-1:0]    s_tuser = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [lrs_pkg::OUT_DW-1:0]   m_tdata;

  // model of the supervisor: register copy plus state
  lrs_pkg::cfg_t     settings;
  logic [1:0]        sup_phase;
  logic              sup_armed;
  logic [31:0]       attempt_t0;
  logic [31:0]       refresh_t0;
  logic [31:0]       retry_t0;
  logic [31:0]       retry_wait;
  logic [31:0]       backoff_now;
  logic signed [7:0] rssi_held;
  logic signed [7:0] rssi_min;
  logic              rssi_min_ok;
  logic [31:0]       events [lrs_pkg::CNT_NUM];

  lrs_pkg::result_t pending_results [$];
  row_t             script [$];
  int               mismatches = 0;
  bit               pause_on = 1'b1;
  bit               settled = 1'b1;   // no beat in flight since the last register write

  link_reconnect_supervisor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the handshakes hang
  initial begin
    #3_000_000;
    $display("link_reconnect_supervisor test failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---- model helpers ----
  function automatic void open_attempt(input logic [31:0] at);
    events[lrs_pkg::CNT_ATTEMPT] += 32'd1;
    sup_phase = lrs_pkg::PHASE_CONNECTING;
    attempt_t0 = at;
  endfunction

  function automatic void take_rssi(input logic [31:0] at, input logic signed [7:0] s);
    rssi_held = s;
    if (!rssi_min_ok || s < rssi_min) begin
      rssi_min = s;
      rssi_min_ok = 1'b1;
    end
    refresh_t0 = at;
  endfunction

  // timeout or drop: park in the retry wait and double the backoff
  function automatic void lose_link(input logic [31:0] at);
    if (sup_phase == lrs_pkg::PHASE_CONNECTED) events[lrs_pkg::CNT_DISCONNECT] += 32'd1;
    else events[lrs_pkg::CNT_TIMEOUT] += 32'd1;
    rssi_held = '0;
    sup_phase = lrs_pkg::PHASE_WAIT;
    retry_t0 = at;
    retry_wait = backoff_now;
    if (backoff_now >= (settings.backoff_max_ms >> 1)) begin
      backoff_now = settings.backoff_max_ms;
    end else begin
      backoff_now = backoff_now << 1;
      if (backoff_now > settings.backoff_max_ms) backoff_now = settings.backoff_max_ms;
    end
  endfunction

  // advance the model by one accepted beat and return the result it owes
  function automatic lrs_pkg::result_t supervise(input lrs_pkg::item_t it);
    lrs_pkg::result_t r;
    logic             pulse_start;
    logic             pulse_drop;
    logic             again;
    logic [31:0]      since;
    pulse_start = 1'b0;
    pulse_drop = 1'b0;
    if (it.op == lrs_pkg::OP_START) begin
      rssi_held = '0;
      backoff_now = settings.backoff_min_ms;
      if (!settings.config_valid) begin
        sup_armed = 1'b0;
        sup_phase = lrs_pkg::PHASE_IDLE;
      end else begin
        sup_armed = 1'b1;
        open_attempt(it.now_ms);
        pulse_start = 1'b1;
      end
    end else if (sup_armed) begin
      if (it.link_up && sup_phase != lrs_pkg::PHASE_CONNECTED) begin
        // link up counts as a connect from any other phase, retry wait included
        again = (events[lrs_pkg::CNT_SUCCESS] != 32'd0);
        sup_phase = lrs_pkg::PHASE_CONNECTED;
        events[lrs_pkg::CNT_SUCCESS] += 32'd1;
        if (again) events[lrs_pkg::CNT_RECONNECT] += 32'd1;
        backoff_now = settings.backoff_min_ms;
        take_rssi(it.now_ms, it.rssi_sample);
      end else if (sup_phase == lrs_pkg::PHASE_CONNECTING) begin
        since = it.now_ms - attempt_t0;
        if (since >= settings.conn_limit_ms) begin
          lose_link(it.now_ms);
          pulse_drop = 1'b1;
        end
      end else if (sup_phase == lrs_pkg::PHASE_CONNECTED) begin
        since = it.now_ms - refresh_t0;
        if (!it.link_up) begin
          lose_link(it.now_ms);
          pulse_drop = 1'b1;
        end else if (since >= settings.refresh_interval_ms) begin
          take_rssi(it.now_ms, it.rssi_sample);
        end
      end else if (sup_phase == lrs_pkg::PHASE_WAIT) begin
        since = it.now_ms - retry_t0;
        if (since >= retry_wait) begin
          open_attempt(it.now_ms);
          pulse_start = 1'b1;
        end
      end
    end
    r.phase            = sup_phase;
    r.start_connect    = pulse_start;
    r.drop_link        = pulse_drop;
    r.rssi_now         = rssi_held;
    r.rssi_floor       = rssi_min_ok ? rssi_min : 8'sd0;
    r.rssi_floor_valid = rssi_min_ok;
    r.attempt_count    = events[lrs_pkg::CNT_ATTEMPT];
    r.success_count    = events[lrs_pkg::CNT_SUCCESS];
    r.reconnect_count  = events[lrs_pkg::CNT_RECONNECT];
    r.disconnect_count = events[lrs_pkg::CNT_DISCONNECT];
    r.timeout_count    = events[lrs_pkg::CNT_TIMEOUT];
    return r;
  endfunction

  function automatic lrs_pkg::result_t unpack_result(input logic [lrs_pkg::OUT_DW-1:0] d);
    lrs_pkg::result_t r;
    r.phase            = d[1:0];
    r.start_connect    = d[2];
    r.drop_link        = d[3];
    r.rssi_now         = d[11:4];
    r.rssi_floor       = d[19:12];
    r.rssi_floor_valid = d[20];
    r.attempt_count    = d[52:21];
    r.success_count    = d[84:53];
    r.reconnect_count  = d[116:85];
    r.disconnect_count = d[148:117];
    r.timeout_count    = d[180:149];
    return r;
  endfunction

  // ---- script rows ----
  function automatic void add_beat(input logic op, input logic [31:0] now,
                                   input logic up, input logic [7:0] rssi,
                                   input logic typed = 1'b0,
                                   input logic [1:0] ph = lrs_pkg::PHASE_IDLE,
                                   input logic st = 1'b0, input logic dr = 1'b0);
    row_t r;
    r = '0;
    r.beat.op = op;
    r.beat.now_ms = now;
    r.beat.link_up = up;
    r.beat.rssi_sample = rssi;
    r.typed = typed;
    r.phase = ph;
    r.start = st;
    r.drop = dr;
    script.push_back(r);
  endfunction

  function automatic void add_write(input logic [lrs_pkg::CFG_AW-1:0] idx,
                                    input logic [31:0] val);
    row_t r;
    r = '0;
    r.wr = 1'b1;
    r.idx = idx;
    r.val = val;
    script.push_back(r);
  endfunction

  // ---- drivers ----
  // Register writes go in only with nothing in flight; back-to-back writes keep
  // cfg_we high, the next beat drops it.
  task automatic write_reg(input logic [lrs_pkg::CFG_AW-1:0] idx, input logic [31:0] val);
    if (!settled) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (pending_results.size() != 0);
      settled = 1'b1;
    end
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      lrs_pkg::REG_CONFIG_VALID:    settings.config_valid = val[0];
      lrs_pkg::REG_CONNECT_TIMEOUT: settings.conn_limit_ms = val;
      lrs_pkg::REG_REFRESH_IVL:     settings.refresh_interval_ms = val;
      lrs_pkg::REG_BACKOFF_MIN:     settings.backoff_min_ms = val;
      lrs_pkg::REG_BACKOFF_MAX:     settings.backoff_max_ms = val;
      default: ;
    endcase
  endtask

  // Hold tvalid through back-to-back beats; drop it only across a gap.
  task automatic send_beat(input lrs_pkg::item_t it, input logic typed,
                           input logic [1:0] ph, input logic st, input logic dr);
    int               gap;
    lrs_pkg::result_t want;
    gap = pause_on ? $urandom_range(0, 11) : 0;
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, it.rssi_sample, it.link_up, it.now_ms};
    s_tuser <= it.op;
    do @(posedge clk); while (s_tready !== 1'b1);
    want = supervise(it);
    if (typed) begin
      want.phase = ph;
      want.start_connect = st;
      want.drop_link = dr;
    end
    pending_results.push_back(want);
    settled = 1'b0;
  endtask

  // result side: stall a random number of cycles before each beat
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = pause_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
    end
  end

  // compare every result beat with the oldest prediction
  always @(posedge clk) begin
    lrs_pkg::result_t got;
    lrs_pkg::result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with nothing pending", 32'd1, 32'd0);
      end else begin
        want = pending_results.pop_front();
        got = unpack_result(m_tdata);
        if (got.phase !== want.phase)
          flag_mismatch("phase", 32'(got.phase), 32'(want.phase));
        if (got.start_connect !== want.start_connect)
          flag_mismatch("start_connect", 32'(got.start_connect), 32'(want.start_connect));
        if (got.drop_link !== want.drop_link)
          flag_mismatch("drop_link", 32'(got.drop_link), 32'(want.drop_link));
        if (got.rssi_now !== want.rssi_now)
          flag_mismatch("rssi_now", 32'(got.rssi_now), 32'(want.rssi_now));
        if (got.rssi_floor !== want.rssi_floor)
          flag_mismatch("rssi_floor", 32'(got.rssi_floor), 32'(want.rssi_floor));
        if (got.rssi_floor_valid !== want.rssi_floor_valid)
          flag_mismatch("rssi_floor_valid", 32'(got.rssi_floor_valid),
                        32'(want.rssi_floor_valid));
        if (got.attempt_count !== want.attempt_count)
          flag_mismatch("attempt_count", got.attempt_count, want.attempt_count);
        if (got.success_count !== want.success_count)
          flag_mismatch("success_count", got.success_count, want.success_count);
        if (got.reconnect_count !== want.reconnect_count)
          flag_mismatch("reconnect_count", got.reconnect_count, want.reconnect_count);
        if (got.disconnect_count !== want.disconnect_count)
          flag_mismatch("disconnect_count", got.disconnect_count, want.disconnect_count);
        if (got.timeout_count !== want.timeout_count)
          flag_mismatch("timeout_count", got.timeout_count, want.timeout_count);
      end
    end
  end

  initial begin
    int             ph;
    int             k;
    int             beats;
    int             waited;
    logic [31:0]    scale;
    logic [31:0]    span;
    logic [31:0]    hop;
    logic [31:0]    clock_ms;
    logic [31:0]    cfg_vals [4];
    logic           cv;
    logic           radio_up;
    lrs_pkg::item_t it;

    // model state after reset
    settings.config_valid = 1'b1;
    settings.conn_limit_ms = lrs_pkg::RST_CONNECT_TIMEOUT;
    settings.refresh_interval_ms = lrs_pkg::RST_REFRESH_IVL;
    settings.backoff_min_ms = lrs_pkg::RST_BACKOFF_MIN;
    settings.backoff_max_ms = lrs_pkg::RST_BACKOFF_MAX;
    sup_phase = lrs_pkg::PHASE_IDLE;
    sup_armed = 1'b0;
    attempt_t0 = '0;
    refresh_t0 = '0;
    retry_t0 = '0;
    retry_wait = '0;
    backoff_now = lrs_pkg::RST_BACKOFF_MIN;
    rssi_held = '0;
    rssi_min = '0;
    rssi_min_ok = 1'b0;
    foreach (events[n]) events[n] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Scripted opening, on the reset register values first.
    add_beat(lrs_pkg::OP_TICK, 32'd0, 1'b1, 8'h7F, 1'b1,
             lrs_pkg::PHASE_IDLE, 1'b0, 1'b0);                    // tick while disarmed
    add_beat(lrs_pkg::OP_START, 32'd100, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_CONNECTING, 1'b1, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd15099, 1'b0, 8'h00);           // one short of timeout
    add_beat(lrs_pkg::OP_TICK, 32'd15100, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_WAIT, 1'b0, 1'b1);
    // link up while waiting to retry still counts as a connect
    add_beat(lrs_pkg::OP_TICK, 32'd15200, 1'b1, 8'h80, 1'b1,
             lrs_pkg::PHASE_CONNECTED, 1'b0, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd20199, 1'b1, 8'h05);           // refresh not due
    add_beat(lrs_pkg::OP_TICK, 32'd20200, 1'b1, 8'h7F);           // refresh
    // start while connected: new attempt, no drop pulse
    add_beat(lrs_pkg::OP_START, 32'd20300, 1'b1, 8'h00, 1'b1,
             lrs_pkg::PHASE_CONNECTING, 1'b1, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd20400, 1'b1, 8'hFF);           // reconnect
    add_beat(lrs_pkg::OP_TICK, 32'd20500, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_WAIT, 1'b0, 1'b1);
    add_beat(lrs_pkg::OP_TICK, 32'd21499, 1'b0, 8'h00);
    add_beat(lrs_pkg::OP_TICK, 32'd21500, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_CONNECTING, 1'b1, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'hFFFF_FFF0, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_WAIT, 1'b0, 1'b1);
    // retry delay measured across the timestamp wrap
    add_beat(lrs_pkg::OP_TICK, 32'h0000_0100, 1'b0, 8'h00);
    add_beat(lrs_pkg::OP_TICK, 32'h0000_07F0, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_CONNECTING, 1'b1, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_WAIT, 1'b0, 1'b1);
    // start without valid settings: idle, disarmed, no pulse
    add_write(lrs_pkg::REG_CONFIG_VALID, 32'd0);
    add_beat(lrs_pkg::OP_START, 32'd5, 1'b1, 8'h00, 1'b1,
             lrs_pkg::PHASE_IDLE, 1'b0, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd6, 1'b1, 8'h40, 1'b1,
             lrs_pkg::PHASE_IDLE, 1'b0, 1'b0);
    // shortest timers, backoff ceiling below its floor
    add_write(lrs_pkg::REG_CONFIG_VALID, 32'd1);
    add_write(lrs_pkg::REG_CONNECT_TIMEOUT, 32'd1);
    add_write(lrs_pkg::REG_REFRESH_IVL, 32'd1);
    add_write(lrs_pkg::REG_BACKOFF_MIN, 32'hFFFF_FFFF);
    add_write(lrs_pkg::REG_BACKOFF_MAX, 32'd1);
    add_beat(lrs_pkg::OP_START, 32'd10, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_CONNECTING, 1'b1, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd11, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_WAIT, 1'b0, 1'b1);
    add_beat(lrs_pkg::OP_TICK, 32'd12, 1'b0, 8'h00);
    // elapsed of all ones meets the largest retry delay
    add_beat(lrs_pkg::OP_TICK, 32'd10, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_CONNECTING, 1'b1, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd11, 1'b1, 8'h81, 1'b1,
             lrs_pkg::PHASE_CONNECTED, 1'b0, 1'b0);
    add_beat(lrs_pkg::OP_TICK, 32'd12, 1'b1, 8'h20);
    add_beat(lrs_pkg::OP_TICK, 32'd12, 1'b0, 8'h00, 1'b1,
             lrs_pkg::PHASE_WAIT, 1'b0, 1'b1);

    foreach (script[i]) begin
      if (script[i].wr) begin
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_beat(script[i].beat, script[i].typed, script[i].phase,
                  script[i].start, script[i].drop);
      end
    end

    // Random part: each round rewrites every register, then streams beats.
    // Timestamps advance by steps scaled to the timers so timeouts, refreshes
    // and retries all fire; an occasional wild jump exercises the wrap.
    clock_ms = '0;
    radio_up = 1'b0;
    for (ph = 0; ph < 10; ph++) begin
      cv = 1'b1;
      case (ph)
        0: begin
          scale = 32'd4;
          foreach (cfg_vals[n]) cfg_vals[n] = 32'd1;
        end
        1: begin
          scale = 32'hFFFF_FFFF;
          foreach (cfg_vals[n]) cfg_vals[n] = 32'hFFFF_FFFF;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: scale = 32'd8;
            1: scale = 32'd64;
            2: scale = 32'd5000;
            3: scale = 32'h0010_0000;
            default: scale = 32'hFFFF_FFFF;
          endcase
          foreach (cfg_vals[n]) cfg_vals[n] = $urandom_range(1, scale);
          if (ph == 2) cv = 1'b0;
        end
      endcase
      write_reg(lrs_pkg::REG_CONFIG_VALID, {31'd0, cv});
      write_reg(lrs_pkg::REG_CONNECT_TIMEOUT, cfg_vals[0]);
      write_reg(lrs_pkg::REG_REFRESH_IVL, cfg_vals[1]);
      write_reg(lrs_pkg::REG_BACKOFF_MIN, cfg_vals[2]);
      write_reg(lrs_pkg::REG_BACKOFF_MAX, cfg_vals[3]);

      pause_on = (ph % 4 != 3);
      beats = cv ? 100 : 20;
      span = scale >> 2;
      if (span == 32'd0) span = 32'd1;
      for (k = 0; k < beats; k++) begin
        it.op = ($urandom_range(0, 99) < 6) ? lrs_pkg::OP_START : lrs_pkg::OP_TICK;
        case ($urandom_range(0, 9))
          0: hop = '0;
          8: hop = $urandom_range(span, span << 1);
          9: hop = $urandom();
          default: hop = $urandom_range(0, span);
        endcase
        clock_ms = clock_ms + hop;
        if ($urandom_range(0, 99) < 12) radio_up = !radio_up;
        it.now_ms = clock_ms;
        it.link_up = radio_up;
        it.rssi_sample = 8'($urandom_range(0, 255));
        send_beat(it, 1'b0, lrs_pkg::PHASE_IDLE, 1'b0, 1'b0);
      end
    end

    // drain: let every owed result arrive, then idle past the pipeline depth
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      flag_mismatch("results never arrived", 32'd0, 32'(pending_results.size()));
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("link_reconnect_supervisor test passed");
    end else begin
      $display("link_reconnect_supervisor test failed");
    end
    $finish;
  end

endmodule
